@@ rtl/btab_pkg.sv @@
// Shared types, constants and codes of the bilinear table interpolator.
package btab_pkg;

  localparam int unsigned MaxEntriesDef = 1024;
  localparam int unsigned NumTabs       = 7;
  localparam int unsigned ValW          = 32;
  localparam int unsigned CntW          = 11;
  localparam int unsigned WordW         = NumTabs * ValW;
  localparam int unsigned AddrW         = 24;
  localparam int unsigned PaddrW        = 4;

  localparam logic [1:0] RegDensW = 2'd0;
  localparam logic [1:0] RegEnerW = 2'd1;
  localparam logic [1:0] RegDensN = 2'd2;
  localparam logic [1:0] RegEnerN = 2'd3;

  localparam logic [ValW-1:0] WidthRst = 32'd65536;
  localparam logic [CntW-1:0] CountRst = 11'd1;

  localparam logic KindLoad  = 1'b0;
  localparam logic KindQuery = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_AXIS,
    S_ADDR,
    S_RD,
    S_MUL,
    S_ACC,
    S_DST,
    S_DIV
  } state_e;

  typedef struct packed {
    logic [CntW-1:0] idx;
    logic [ValW-1:0] lw;
    logic [ValW-1:0] hw;
    logic            on_edge;
  } btab_axis_t;

  typedef struct packed {
    logic        kind;
    logic [9:0]  entry_index;
    logic [31:0] qel_pin_in;
    logic [31:0] cex_pin_in;
    logic [31:0] qel_pip_in;
    logic [31:0] cex_pip_in;
    logic [31:0] qel_piz_in;
    logic [31:0] cex_piz_in;
    logic [31:0] absorb_in;
    logic [31:0] density;
    logic [31:0] energy;
  } btab_in_t;

  typedef struct packed {
    logic [31:0] qel_pin_out;
    logic [31:0] cex_pin_out;
    logic [31:0] qel_pip_out;
    logic [31:0] cex_pip_out;
    logic [31:0] qel_piz_out;
    logic [31:0] cex_piz_out;
    logic [31:0] absorb_out;
  } btab_out_t;

endpackage

@@ rtl/btab_axis.sv @@
// Per-axis bit-serial divider giving cell index, edge flag and weights.
module btab_axis (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [31:0]                val_i,
  input  logic [31:0]                width_i,
  input  logic [10:0]                count_i,
  output btab_pkg::btab_axis_t       res_o,
  output logic                       done_o
);
  import btab_pkg::*;

  logic            busy_q, busy_d;
  logic [4:0]      cnt_q, cnt_d;
  logic [ValW-1:0] rem_q, rem_d, quo_q, quo_d;
  logic [ValW:0]   trial;
  logic [ValW:0]   diff;
  logic            ge;
  logic [CntW-1:0] last;

  assign trial = {rem_q, quo_q[ValW-1]};
  assign diff  = trial - {1'b0, width_i};
  assign ge    = trial >= {1'b0, width_i};
  assign done_o = busy_q && (cnt_q == 5'd31);

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = val_i;
    end else if (busy_q) begin
      cnt_d = cnt_q + 5'd1;
      rem_d = ge ? diff[ValW-1:0] : trial[ValW-1:0];
      quo_d = {quo_q[ValW-2:0], ge};
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign last = count_i - 11'd1;

  always_comb begin
    res_o.on_edge = quo_q >= {21'd0, last};
    if (res_o.on_edge) begin
      res_o.idx = last;
      res_o.lw  = width_i;
      res_o.hw  = '0;
    end else begin
      res_o.idx = quo_q[CntW-1:0];
      res_o.lw  = width_i - rem_q;
      res_o.hw  = rem_q;
    end
  end

endmodule

@@ rtl/btab_mem.sv @@
// Single-port table memory holding all seven values of one grid entry per word.
module btab_mem #(
  parameter int unsigned DEPTH = btab_pkg::MaxEntriesDef,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               addr_i,
  input  logic [btab_pkg::WordW-1:0]  wdata_i,
  output logic [btab_pkg::WordW-1:0]  rdata_o
);
  import btab_pkg::*;

  logic [WordW-1:0] mem [DEPTH];
  logic [WordW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/btab_qdiv.sv @@
// Saturating bit-serial divider of a 128-bit weighted sum by the cell area.
module btab_qdiv (
  input  logic         clk_i,
  input  logic         start_i,
  input  logic         step_i,
  input  logic [127:0] num_i,
  input  logic [63:0]  den_i,
  output logic [31:0]  quo_o
);
  import btab_pkg::*;

  logic        sat_q;
  logic [63:0] rem_q;
  logic [31:0] low_q;
  logic [64:0] trial;
  logic [64:0] diff;
  logic        ge;

  assign trial = {rem_q, low_q[31]};
  assign diff  = trial - {1'b0, den_i};
  assign ge    = trial >= {1'b0, den_i};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sat_q <= num_i[127:32] >= {32'd0, den_i};
      rem_q <= num_i[95:32];
      low_q <= num_i[31:0];
    end else if (step_i) begin
      rem_q <= ge ? diff[63:0] : trial[63:0];
      low_q <= {low_q[30:0], ge};
    end
  end

  assign quo_o = sat_q ? 32'hFFFF_FFFF : low_q;

endmodule

@@ rtl/bilinear_table_interpolator_unit.sv @@
// Top level: configuration registers, sequencer, multiply-accumulate and result register.
//
//  Channel   Direction  Handshake           Beat
//  in        input      in_valid_i/stall_o  btab_in_t (load or query)
//  out       output     out_valid_o/stall_i btab_out_t (seven interpolated values)
//  config    input      APB psel/penable    one 32-bit register write or read
//
// A load beat writes one memory word, unless its entry index lies beyond the table. A query
// runs the two axis divisions side by side, an address set-up step, the four single-port memory
// reads and multiply-accumulates in turn, a divider set-up step and the final division.
// Reset clears control state and presets config registers; the table is undefined until loaded.
// A finished result waits in the output register and a new beat is taken meanwhile;
// a second result waits until the first has left.
module bilinear_table_interpolator_unit #(
  parameter int unsigned MAX_ENTRIES = btab_pkg::MaxEntriesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  btab_pkg::btab_in_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output btab_pkg::btab_out_t           out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [btab_pkg::PaddrW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import btab_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ENTRIES);
  localparam logic [AddrW-1:0] MaxEnt = AddrW'(MAX_ENTRIES);

  state_e state_q, state_d;

  logic [ValW-1:0] dens_w_q, ener_w_q;
  logic [CntW-1:0] dens_n_q, ener_n_q;
  logic [ValW-1:0] dw_eff, ew_eff;
  logic [CntW-1:0] dn_eff, en_eff;

  logic            in_acc, load_we, query_go;
  logic            cfg_we;

  btab_axis_t      dax, eax;
  logic            d_done, e_done;

  logic [63:0]     den_q;
  logic [AddrW-1:0] a00_q;
  logic [AddrW-1:0] rd_addr;
  logic            rd_ok_q;
  logic [1:0]      nb_q;
  logic [63:0]     wprod_q;
  logic [ValW-1:0] wd_sel, we_sel;
  logic [5:0]      cnt_q;

  logic [WordW-1:0] rdata;
  logic [WordW-1:0] wword;
  logic [AW-1:0]    mem_addr;
  logic             mem_en;

  logic [63:0]     plo_q [NumTabs];
  logic [63:0]     phi_q [NumTabs];
  logic [127:0]    acc_q [NumTabs];
  logic [31:0]     quo   [NumTabs];

  logic            out_valid_q;
  btab_out_t       out_data_q;
  logic            fin_load;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dens_w_q <= WidthRst;
      ener_w_q <= WidthRst;
      dens_n_q <= CountRst;
      ener_n_q <= CountRst;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        RegDensW: dens_w_q <= pwdata;
        RegEnerW: ener_w_q <= pwdata;
        RegDensN: dens_n_q <= pwdata[CntW-1:0];
        RegEnerN: ener_n_q <= pwdata[CntW-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegDensW: prdata = dens_w_q;
      RegEnerW: prdata = ener_w_q;
      RegDensN: prdata = {21'd0, dens_n_q};
      RegEnerN: prdata = {21'd0, ener_n_q};
      default:  prdata = '0;
    endcase
  end

  assign dw_eff = (dens_w_q == '0) ? 32'd1 : dens_w_q;
  assign ew_eff = (ener_w_q == '0) ? 32'd1 : ener_w_q;
  assign dn_eff = (dens_n_q == '0) ? 11'd1 : dens_n_q;
  assign en_eff = (ener_n_q == '0) ? 11'd1 : ener_n_q;

  // Input handshake
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign load_we    = in_acc && (in_data_i.kind == KindLoad)
                      && ({14'd0, in_data_i.entry_index} < MaxEnt);
  assign query_go   = in_acc && (in_data_i.kind == KindQuery);

  // Axis dividers
  btab_axis u_dax (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (query_go),
    .val_i   (in_data_i.density),
    .width_i (dw_eff),
    .count_i (dn_eff),
    .res_o   (dax),
    .done_o  (d_done)
  );

  btab_axis u_eax (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (query_go),
    .val_i   (in_data_i.energy),
    .width_i (ew_eff),
    .count_i (en_eff),
    .res_o   (eax),
    .done_o  (e_done)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (query_go) state_d = S_AXIS;
      S_AXIS: if (d_done && e_done) state_d = S_ADDR;
      S_ADDR: state_d = S_RD;
      S_RD:   state_d = S_MUL;
      S_MUL:  state_d = S_ACC;
      S_ACC:  state_d = (nb_q == 2'd3) ? S_DST : S_RD;
      S_DST:  state_d = S_DIV;
      S_DIV:  if (cnt_q == 6'd32 && fin_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    fin_load = 1'b0;
    unique case (state_q)
      S_DIV:   fin_load = (cnt_q == 6'd32) && (!out_valid_q || !out_stall_i);
      default: fin_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      nb_q    <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_ADDR) begin
        nb_q <= '0;
      end else if (state_q == S_ACC) begin
        nb_q <= nb_q + 2'd1;
      end
      if (state_q == S_DST) begin
        cnt_q <= '0;
      end else if (state_q == S_DIV && cnt_q != 6'd32) begin
        cnt_q <= cnt_q + 6'd1;
      end
    end
  end

  // Neighbour addressing
  always_comb begin
    rd_addr = a00_q;
    if (nb_q[0] && !dax.on_edge) begin
      rd_addr = rd_addr + {13'd0, en_eff};
    end
    if (nb_q[1] && !eax.on_edge) begin
      rd_addr = rd_addr + AddrW'(1);
    end
  end

  assign wd_sel = nb_q[0] ? dax.hw : dax.lw;
  assign we_sel = nb_q[1] ? eax.hw : eax.lw;

  always_ff @(posedge clk_i) begin
    if (query_go) begin
      den_q <= {32'd0, dw_eff} * {32'd0, ew_eff};
    end
    if (state_q == S_ADDR) begin
      a00_q <= AddrW'(22'(dax.idx) * 22'(en_eff)) + {13'd0, eax.idx};
    end
    if (state_q == S_RD) begin
      rd_ok_q <= rd_addr < MaxEnt;
      wprod_q <= {32'd0, wd_sel} * {32'd0, we_sel};
    end
  end

  // Table memory
  assign wword = {in_data_i.absorb_in, in_data_i.cex_piz_in, in_data_i.qel_piz_in,
                  in_data_i.cex_pip_in, in_data_i.qel_pip_in, in_data_i.cex_pin_in,
                  in_data_i.qel_pin_in};
  assign mem_addr = load_we ? AW'(in_data_i.entry_index) : AW'(rd_addr);
  assign mem_en   = load_we || (state_q == S_RD);

  btab_mem #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (load_we),
    .addr_i  (mem_addr),
    .wdata_i (wword),
    .rdata_o (rdata)
  );

  // Multiply-accumulate lanes and final dividers
  for (genvar t = 0; t < NumTabs; t++) begin : g_lane
    logic [ValW-1:0] val;
    assign val = rd_ok_q ? rdata[t*ValW +: ValW] : '0;

    always_ff @(posedge clk_i) begin
      if (state_q == S_ADDR) begin
        acc_q[t] <= '0;
      end else if (state_q == S_ACC) begin
        acc_q[t] <= acc_q[t] + {64'd0, plo_q[t]} + {32'd0, phi_q[t], 32'd0};
      end
      if (state_q == S_MUL) begin
        plo_q[t] <= {32'd0, wprod_q[31:0]} * {32'd0, val};
        phi_q[t] <= {32'd0, wprod_q[63:32]} * {32'd0, val};
      end
    end

    btab_qdiv u_qdiv (
      .clk_i   (clk_i),
      .start_i (state_q == S_DST),
      .step_i  ((state_q == S_DIV) && (cnt_q != 6'd32)),
      .num_i   (acc_q[t]),
      .den_i   (den_q),
      .quo_o   (quo[t])
    );
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_load) begin
      out_data_q.qel_pin_out <= quo[0];
      out_data_q.cex_pin_out <= quo[1];
      out_data_q.qel_pip_out <= quo[2];
      out_data_q.cex_pip_out <= quo[3];
      out_data_q.qel_piz_out <= quo[4];
      out_data_q.cex_piz_out <= quo[5];
      out_data_q.absorb_out  <= quo[6];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
